[hw/rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared sizes, command codes and status codes of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // number of free lists, one per block order
  localparam int unsigned MaxOrder  = 11;
  // pages held in the page tables
  localparam int unsigned PoolDepth = 4096;

  localparam int unsigned PageW  = 12;  // page index width
  localparam int unsigned OrderW = 4;   // block order width
  localparam int unsigned CntW   = 13;  // page count width
  localparam int unsigned CmdW   = 2;

  // command codes
  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_INIT  = 2'd2;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOMEM = 1'b1;

endpackage

[hw/rtl/buddy_page_allocator_top.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator: per-order free lists in registers, page tables and
// list links in one-write one-read memories, driven by one sequencer.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// cfg       in         cfg_we_i               cfg_wdata_i (pool pages)
// in        in         in_valid_i/in_ready_o  cmd_i, block_order_i, page_index_i
// out       out        out_valid_o/out_ready_i status_o, granted_page_o,
//                                              free_page_total_o
//
// one command at a time; each memory access is one step of the sequencer
// (registered reads, so a lookup has an address step and a read step).
// free repeats its merge steps per level; allocate searches the orders
// upward, unlinks the block found and repeats its split steps per level.
// initialize sweeps all 4096 table entries, then frees each pool page in
// turn. after reset a clearing pass runs with in_ready_o low. a waiting
// result holds the sequencer in its final step until the out transfer.
module buddy_page_allocator_top
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [OrderW-1:0] block_order_i,
  input  logic [PageW-1:0]  page_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [PageW-1:0]  granted_page_o,
  output logic [CntW-1:0]   free_page_total_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_INI_NEXT, ST_REL_CHK, ST_REL_RD, ST_MRG_CHK,
    ST_MRG_TST, ST_MRG_RMP, ST_MRG_W1, ST_MRG_W2, ST_ALC_SRCH, ST_SPL_CHK,
    ST_SPL_HALF, ST_APP, ST_RM_RD, ST_RM_UPD, ST_DONE
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [CntW-1:0]   pool_q, live_q, live_d, idx_q, idx_d, total_q, total_d;
  logic [PageW-1:0]  p_q, p_d, b_q, b_d, n_q, n_d;
  logic [OrderW-1:0] k_q, k_d, want_q, want_d, lk_q, lk_d;
  logic              init_q, init_d, res_st_q, res_st_d;
  logic [PageW-1:0]  res_pg_q, res_pg_d;
  logic              out_valid_q;
  logic              st_o_q;
  logic [PageW-1:0]  pg_o_q;
  logic [CntW-1:0]   tot_o_q;

  logic [PageW-1:0] head_q [MaxOrder];
  logic [PageW-1:0] tail_q [MaxOrder];
  logic [CntW-1:0]  len_q  [MaxOrder];
  logic [PageW-1:0] head_d [MaxOrder];
  logic [PageW-1:0] tail_d [MaxOrder];
  logic [CntW-1:0]  len_d  [MaxOrder];

  // page tables and list links
  logic              taken_mem [PoolDepth];
  logic [OrderW-1:0] order_mem [PoolDepth];
  logic [PageW-1:0]  nxt_mem   [PoolDepth];
  logic [PageW-1:0]  prv_mem   [PoolDepth];

  logic              tk_we, or_we, nx_we, pv_we;
  logic [PageW-1:0]  tk_wa, or_wa, nx_wa, pv_wa, pi_ra, lk_ra;
  logic              tk_wd;
  logic [OrderW-1:0] or_wd;
  logic [PageW-1:0]  nx_wd, pv_wd;
  logic              tk_rd_q;
  logic [OrderW-1:0] or_rd_q;
  logic [PageW-1:0]  nx_rd_q, pv_rd_q;

  // list view at the selected order
  logic              lk_ok;
  logic [OrderW-1:0] lk_ix;
  logic [PageW-1:0]  cur_head, cur_tail;
  logic [CntW-1:0]   cur_len;
  logic [CntW-1:0]   lk_pages;
  logic [PageW-1:0]  k_bit, lo_pg, hi_pg;
  logic [OrderW-1:0] k_inc;
  logic              out_free;
  state_e            rel_end;

  assign lk_ok    = lk_q < OrderW'(MaxOrder);
  assign lk_ix    = lk_ok ? lk_q : '0;
  assign cur_head = head_q[lk_ix];
  assign cur_tail = tail_q[lk_ix];
  assign cur_len  = len_q[lk_ix];
  assign lk_pages = CntW'(1) << lk_q;
  assign k_bit    = PageW'(1) << k_q;
  assign k_inc    = k_q + OrderW'(1);
  assign lo_pg    = (p_q < b_q) ? p_q : b_q;
  assign hi_pg    = (p_q < b_q) ? b_q : p_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign rel_end  = init_q ? ST_INI_NEXT : ST_DONE;

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = st_o_q;
  assign granted_page_o    = pg_o_q;
  assign free_page_total_o = tot_o_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    live_d   = live_q;
    idx_d    = idx_q;
    total_d  = total_q;
    p_d      = p_q;
    b_d      = b_q;
    n_d      = n_q;
    k_d      = k_q;
    want_d   = want_q;
    lk_d     = lk_q;
    init_d   = init_q;
    res_st_d = res_st_q;
    res_pg_d = res_pg_q;
    head_d   = head_q;
    tail_d   = tail_q;
    len_d    = len_q;
    tk_we = 1'b0; tk_wa = p_q; tk_wd = 1'b0;
    or_we = 1'b0; or_wa = p_q; or_wd = '0;
    nx_we = 1'b0; nx_wa = n_q; nx_wd = n_q;
    pv_we = 1'b0; pv_wa = n_q; pv_wd = n_q;
    pi_ra = p_q;
    lk_ra = n_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_st_d = STATUS_OK;
          res_pg_d = '0;
          init_d   = 1'b0;
          case (cmd_i)
            CMD_ALLOC: begin
              want_d = block_order_i;
              lk_d   = block_order_i;
              if (block_order_i >= OrderW'(MaxOrder)) begin
                res_st_d = STATUS_NOMEM;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_ALC_SRCH;
              end
            end
            CMD_FREE: begin
              p_d     = page_index_i;
              state_d = ST_REL_CHK;
            end
            CMD_INIT: begin
              live_d  = (pool_q > CntW'(PoolDepth)) ? CntW'(PoolDepth) : pool_q;
              idx_d   = '0;
              total_d = '0;
              init_d  = 1'b1;
              for (int i = 0; i < MaxOrder; i++) begin
                head_d[i] = '0;
                tail_d[i] = '0;
                len_d[i]  = '0;
              end
              state_d = ST_CLR;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // table sweep: every page taken at order 0
      ST_CLR: begin
        tk_we = 1'b1; tk_wa = idx_q[PageW-1:0]; tk_wd = 1'b1;
        or_we = 1'b1; or_wa = idx_q[PageW-1:0]; or_wd = '0;
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(PoolDepth - 1)) begin
          idx_d   = '0;
          state_d = init_q ? ST_INI_NEXT : ST_IDLE;
        end
      end

      // free pool pages one by one
      ST_INI_NEXT: begin
        if (idx_q < live_q) begin
          p_d     = idx_q[PageW-1:0];
          idx_d   = idx_q + CntW'(1);
          state_d = ST_REL_CHK;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_REL_CHK: begin
        pi_ra = p_q;
        state_d = ({1'b0, p_q} >= live_q) ? rel_end : ST_REL_RD;
      end

      ST_REL_RD: begin
        if (!tk_rd_q) begin
          state_d = rel_end;
        end else begin
          k_d = (or_rd_q >= OrderW'(MaxOrder)) ? OrderW'(MaxOrder - 1) : or_rd_q;
          tk_we = 1'b1; tk_wa = p_q; tk_wd = 1'b0;
          or_we = 1'b1; or_wa = p_q; or_wd = k_d;
          lk_d    = k_d;
          n_d     = p_q;
          ret_d   = ST_MRG_CHK;
          state_d = ST_APP;
        end
      end

      // look up the buddy
      ST_MRG_CHK: begin
        b_d   = p_q ^ k_bit;
        pi_ra = b_d;
        if (k_inc >= OrderW'(MaxOrder) || {1'b0, b_d} >= live_q) begin
          state_d = rel_end;
        end else begin
          state_d = ST_MRG_TST;
        end
      end

      ST_MRG_TST: begin
        if (tk_rd_q || or_rd_q != k_q) begin
          state_d = rel_end;
        end else begin
          lk_d    = k_q;
          n_d     = b_q;
          ret_d   = ST_MRG_RMP;
          state_d = ST_RM_RD;
        end
      end

      ST_MRG_RMP: begin
        lk_d    = k_q;
        n_d     = p_q;
        ret_d   = ST_MRG_W1;
        state_d = ST_RM_RD;
      end

      ST_MRG_W1: begin
        or_we = 1'b1; or_wa = lo_pg; or_wd = k_inc;
        tk_we = 1'b1; tk_wa = hi_pg; tk_wd = 1'b1;
        state_d = ST_MRG_W2;
      end

      ST_MRG_W2: begin
        or_we = 1'b1; or_wa = hi_pg; or_wd = k_inc;
        lk_d    = k_inc;
        n_d     = lo_pg;
        p_d     = lo_pg;
        k_d     = k_inc;
        ret_d   = ST_MRG_CHK;
        state_d = ST_APP;
      end

      // search the lists upward for a block
      ST_ALC_SRCH: begin
        if (!lk_ok) begin
          res_st_d = STATUS_NOMEM;
          state_d  = ST_DONE;
        end else if (cur_len == '0) begin
          lk_d = lk_q + OrderW'(1);
        end else begin
          p_d   = cur_head;
          k_d   = lk_q;
          tk_we = 1'b1; tk_wa = cur_head; tk_wd = 1'b1;
          n_d     = cur_head;
          ret_d   = ST_SPL_CHK;
          state_d = ST_RM_RD;
        end
      end

      // split down to the wanted order
      ST_SPL_CHK: begin
        if (k_q > want_q) begin
          k_d   = k_q - OrderW'(1);
          or_we = 1'b1; or_wa = p_q; or_wd = k_d;
          state_d = ST_SPL_HALF;
        end else begin
          res_pg_d = p_q;
          state_d  = ST_DONE;
        end
      end

      ST_SPL_HALF: begin
        b_d = p_q ^ k_bit;
        if ({1'b0, b_d} < live_q) begin
          or_we = 1'b1; or_wa = b_d; or_wd = k_q;
          tk_we = 1'b1; tk_wa = b_d; tk_wd = 1'b0;
          lk_d    = k_q;
          n_d     = b_d;
          ret_d   = ST_SPL_CHK;
          state_d = ST_APP;
        end else begin
          state_d = ST_SPL_CHK;
        end
      end

      // append n at the tail of list lk
      ST_APP: begin
        if (cur_len == '0) begin
          head_d[lk_ix] = n_q;
        end else begin
          nx_we = 1'b1; nx_wa = cur_tail; nx_wd = n_q;
          pv_we = 1'b1; pv_wa = n_q;      pv_wd = cur_tail;
        end
        tail_d[lk_ix] = n_q;
        len_d[lk_ix]  = cur_len + CntW'(1);
        total_d       = total_q + lk_pages;
        state_d       = ret_q;
      end

      // unlink n from list lk
      ST_RM_RD: begin
        lk_ra   = n_q;
        state_d = ST_RM_UPD;
      end

      ST_RM_UPD: begin
        if (cur_len != '0) begin
          if (cur_len == CntW'(1)) begin
            head_d[lk_ix] = '0;
            tail_d[lk_ix] = '0;
          end else if (n_q == cur_head) begin
            head_d[lk_ix] = nx_rd_q;
          end else if (n_q == cur_tail) begin
            tail_d[lk_ix] = pv_rd_q;
          end else begin
            nx_we = 1'b1; nx_wa = pv_rd_q; nx_wd = nx_rd_q;
            pv_we = 1'b1; pv_wa = nx_rd_q; pv_wd = pv_rd_q;
          end
          len_d[lk_ix] = cur_len - CntW'(1);
          total_d      = total_q - lk_pages;
        end
        state_d = ret_q;
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state, list heads and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ret_q       <= ST_IDLE;
      pool_q      <= CntW'(PoolDepth);
      live_q      <= CntW'(PoolDepth);
      idx_q       <= '0;
      total_q     <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxOrder; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      live_q  <= live_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      init_q  <= init_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    b_q      <= b_d;
    n_q      <= n_d;
    k_q      <= k_d;
    want_q   <= want_d;
    lk_q     <= lk_d;
    res_st_q <= res_st_d;
    res_pg_q <= res_pg_d;
    if (state_q == ST_DONE && out_free) begin
      st_o_q  <= res_st_q;
      pg_o_q  <= res_pg_q;
      tot_o_q <= total_q;
    end
  end

  // page table memories
  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      taken_mem[tk_wa] <= tk_wd;
    end
    tk_rd_q <= taken_mem[pi_ra];
  end

  always_ff @(posedge clk_i) begin
    if (or_we) begin
      order_mem[or_wa] <= or_wd;
    end
    or_rd_q <= order_mem[pi_ra];
  end

  // list link memories
  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nxt_mem[nx_wa] <= nx_wd;
    end
    nx_rd_q <= nxt_mem[lk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prv_mem[pv_wa] <= pv_wd;
    end
    pv_rd_q <= prv_mem[lk_ra];
  end

endmodule

[bench/buddy_page_allocator_checker.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches the command and result channels of the buddy page allocator, keeps
// its own copy of the page tables and free lists, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [OrderW-1:0] block_order_i,
  input  logic [PageW-1:0]  page_index_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              status_i,
  input  logic [PageW-1:0]  granted_page_i,
  input  logic [CntW-1:0]   free_page_total_i,
  output int                error_count_o,
  output int                pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             status;
    logic [PageW-1:0] page;
    logic [CntW-1:0]  total;
  } alloc_result_t;

  // shadow page tables and free lists
  bit                  page_busy [PoolDepth];
  logic [OrderW-1:0]   page_order [PoolDepth];
  logic [PageW-1:0]    link_next [PoolDepth];
  logic [PageW-1:0]    link_prev [PoolDepth];
  logic [PageW-1:0]    list_first [MaxOrder];
  logic [PageW-1:0]    list_last [MaxOrder];
  int unsigned         list_len [MaxOrder];
  logic [CntW-1:0]     pool_size_reg;
  int unsigned         pages_live;

  alloc_result_t       expected_results[$];
  int                  mismatches;
  int                  pending;

  initial begin
    for (int i = 0; i < PoolDepth; i++) begin
      page_busy[i]  = 1'b1;
      page_order[i] = '0;
      link_next[i]  = '0;
      link_prev[i]  = '0;
    end
    for (int k = 0; k < MaxOrder; k++) begin
      list_first[k] = '0;
      list_last[k]  = '0;
      list_len[k]   = 0;
    end
    pool_size_reg = CntW'(PoolDepth);
    pages_live    = PoolDepth;
    mismatches    = 0;
    pending       = 0;
  end

  assign error_count_o   = mismatches;
  assign pending_count_o = pending;

  // append a block at the tail of its order's list
  function automatic void list_push(int unsigned k, int unsigned n);
    if (list_len[k] == 0) begin
      list_first[k] = PageW'(n);
    end else begin
      link_next[list_last[k]] = PageW'(n);
      link_prev[n] = list_last[k];
    end
    list_last[k] = PageW'(n);
    list_len[k]++;
  endfunction

  // unlink a block from anywhere in its order's list
  function automatic void list_unlink(int unsigned k, int unsigned n);
    if (list_len[k] == 0) return;
    if (list_len[k] == 1) begin
      list_first[k] = '0;
      list_last[k]  = '0;
    end else if (n == list_first[k]) begin
      list_first[k] = link_next[n];
    end else if (n == list_last[k]) begin
      list_last[k] = link_prev[n];
    end else begin
      link_next[link_prev[n]] = link_next[n];
      link_prev[link_next[n]] = link_prev[n];
    end
    list_len[k]--;
  endfunction

  // free a block and merge it upward with free buddies
  function automatic void release_block(int unsigned p);
    int unsigned k, b, lo, hi;
    if (p >= pages_live || !page_busy[p]) return;
    k = page_order[p];
    if (k >= MaxOrder) begin
      k = MaxOrder - 1;
      page_order[p] = OrderW'(k);
    end
    page_busy[p] = 1'b0;
    list_push(k, p);
    while (k + 1 < MaxOrder) begin
      b = p ^ (1 << k);
      if (b >= pages_live || page_busy[b] || page_order[b] != k) break;
      list_unlink(k, b);
      list_unlink(k, p);
      lo = (p < b) ? p : b;
      hi = (p < b) ? b : p;
      page_order[lo] = OrderW'(k + 1);
      page_order[hi] = OrderW'(k + 1);
      page_busy[hi]  = 1'b1;
      list_push(k + 1, lo);
      p = lo;
      k++;
    end
  endfunction

  // take the smallest fitting block and split it down to the wanted order
  function automatic bit take_block(int unsigned want, output int unsigned got);
    int unsigned k, p, b;
    got = 0;
    k = want;
    while (k < MaxOrder && list_len[k] == 0) k++;
    if (k >= MaxOrder) return 1'b0;
    p = list_first[k];
    page_busy[p] = 1'b1;
    list_unlink(k, p);
    while (k > want) begin
      k--;
      page_order[p] = OrderW'(k);
      b = p ^ (1 << k);
      if (b < pages_live) begin
        page_order[b] = OrderW'(k);
        page_busy[b]  = 1'b0;
        list_push(k, b);
      end
    end
    got = p;
    return 1'b1;
  endfunction

  // rebuild the pool from the latched size
  function automatic void rebuild_pool();
    pages_live = (pool_size_reg < PoolDepth) ? pool_size_reg : PoolDepth;
    for (int k = 0; k < MaxOrder; k++) begin
      list_len[k]   = 0;
      list_first[k] = '0;
      list_last[k]  = '0;
    end
    for (int i = 0; i < PoolDepth; i++) begin
      page_busy[i]  = 1'b1;
      page_order[i] = '0;
    end
    for (int unsigned i = 0; i < pages_live; i++) release_block(i);
  endfunction

  // apply one command and return the result it should produce
  function automatic alloc_result_t apply_command(logic [CmdW-1:0] cmd,
                                                  logic [OrderW-1:0] ord,
                                                  logic [PageW-1:0] pg);
    alloc_result_t r;
    int unsigned got, sum;
    r = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (ord < MaxOrder && take_block(ord, got)) r.page = PageW'(got);
        else r.status = STATUS_NOMEM;
      end
      CMD_FREE: release_block(pg);
      CMD_INIT: rebuild_pool();
      default: ;
    endcase
    sum = 0;
    for (int k = 0; k < MaxOrder; k++) sum += list_len[k] << k;
    r.total = CntW'(sum);
    return r;
  endfunction

  // track config writes, predict on command transfers, compare on result transfers
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) pool_size_reg <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_command(cmd_i, block_order_i, page_index_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%t: unexpected result status=%0d page=%0d total=%0d", $realtime,
                   status_i, granted_page_i, free_page_total_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== status_i) begin
            $display("%t: status expected %0d actual %0d", $realtime, want.status, status_i);
            mismatches++;
          end
          if (want.page !== granted_page_i) begin
            $display("%t: granted_page expected %0d actual %0d", $realtime, want.page,
                     granted_page_i);
            mismatches++;
          end
          if (want.total !== free_page_total_i) begin
            $display("%t: free_page_total expected %0d actual %0d", $realtime, want.total,
                     free_page_total_i);
            mismatches++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[bench/buddy_page_allocator_top_tb.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_top_tb
// Drives allocate, free and initialize commands into the buddy allocator
// across several pool sizes and handshake pressure settings; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_tb;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CntW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CmdW-1:0]   cmd_i = '0;
  logic [OrderW-1:0] block_order_i = '0;
  logic [PageW-1:0]  page_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              status_o;
  logic [PageW-1:0]  granted_page_o;
  logic [CntW-1:0]   free_page_total_o;
  int                error_count;
  int                pending_count;

  // stimulus-side bookkeeping
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  int                holdoff_request = 0;
  int                holdoff_left = 0;
  int                cmds_sent = 0;
  int                results_seen = 0;
  logic [CmdW-1:0]   cmds_in_flight[$];
  logic [PageW-1:0]  held_pages[$];

  always #10 clk_i = ~clk_i;

  buddy_page_allocator_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .block_order_i, .page_index_i,
    .out_valid_o, .out_ready_i, .status_o, .granted_page_o, .free_page_total_o
  );

  buddy_page_allocator_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .block_order_i, .page_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .granted_page_i(granted_page_o), .free_page_total_i(free_page_total_o),
    .error_count_o(error_count), .pending_count_o(pending_count)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holdoff_request > 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // remember granted pages so later frees hit real blocks
  always @(posedge clk_i) begin
    logic [CmdW-1:0] c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      c = cmds_in_flight.pop_front();
      if (c == CMD_INIT) held_pages.delete();
      else if (c == CMD_ALLOC && status_o == STATUS_OK) held_pages.push_back(granted_page_o);
    end
  end

  // offer one command and hold it until the transfer
  task automatic send_cmd(logic [CmdW-1:0] c, logic [OrderW-1:0] o, logic [PageW-1:0] p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    block_order_i <= o;
    page_index_i  <= p;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    cmds_in_flight.push_back(c);
    cmds_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmds_sent != results_seen) @(posedge clk_i);
  endtask

  // change the pool size while idle, then rebuild the pool
  task automatic set_pool(int unsigned pages);
    wait_drained();
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CntW'(pages);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    send_cmd(CMD_INIT, '0, '0);
  endtask

  // mostly allocate/free of live blocks, some noise
  task automatic random_cmds(int n, bit allow_init);
    int pick, idx;
    logic [OrderW-1:0] o;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40 && held_pages.size() > 0) begin
        idx = $urandom_range(held_pages.size() - 1);
        send_cmd(CMD_FREE, OrderW'($urandom), held_pages[idx]);
        held_pages.delete(idx);
      end else if (pick < 48) begin
        send_cmd(CMD_FREE, OrderW'($urandom), PageW'($urandom));
      end else if (pick < 51) begin
        send_cmd(CmdUnused, OrderW'($urandom), PageW'($urandom));
      end else if (pick < 54 && allow_init) begin
        send_cmd(CMD_INIT, OrderW'($urandom), PageW'($urandom));
      end else begin
        if ($urandom_range(19) == 0) o = OrderW'($urandom_range(15));
        else if ($urandom_range(3) == 0) o = OrderW'($urandom_range(10));
        else o = OrderW'($urandom_range(3));
        send_cmd(CMD_ALLOC, o, PageW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: before any initialize, then the full pool
    send_cmd(CMD_ALLOC, 4'd0, '0);
    send_cmd(CMD_FREE, '0, 12'd5);
    send_cmd(CMD_FREE, '0, 12'd5);
    send_cmd(CMD_FREE, '0, 12'd4095);
    send_cmd(CMD_INIT, '0, '0);
    send_cmd(CMD_ALLOC, 4'd0, '0);
    send_cmd(CMD_ALLOC, 4'd10, 12'hfff);
    send_cmd(CMD_ALLOC, 4'd11, '0);
    send_cmd(CMD_ALLOC, 4'd15, '0);
    send_cmd(CMD_ALLOC, 4'd3, '0);
    send_cmd(CmdUnused, 4'd15, 12'hfff);
    send_cmd(CMD_FREE, '0, 12'd4095);
    send_cmd(CMD_FREE, '0, 12'd0);
    send_cmd(CMD_FREE, '0, 12'd0);
    send_cmd(CMD_ALLOC, 4'd10, '0);
    send_cmd(CMD_ALLOC, 4'd10, '0);
    send_cmd(CMD_ALLOC, 4'd10, '0);
    send_cmd(CMD_ALLOC, 4'd10, '0);

    // directed: tiny pool, free outside the pool
    set_pool(13);
    send_cmd(CMD_FREE, '0, 12'd13);
    send_cmd(CMD_FREE, '0, 12'd4095);
    send_cmd(CMD_ALLOC, 4'd3, '0);
    send_cmd(CMD_ALLOC, 4'd3, '0);
    send_cmd(CMD_ALLOC, 4'd0, '0);

    // no idling, full pool
    set_pool(4096);
    random_cmds(100, 1'b0);

    // single-page pool, sender mostly idle
    sender_idle_pct = 81;
    set_pool(1);
    random_cmds(30, 1'b1);

    // oversize setting acts as the full pool, receiver mostly stalling
    sender_idle_pct = 0;
    receiver_stall_pct = 81;
    set_pool(8191);
    random_cmds(80, 1'b0);

    // both sides idle a little, with a full drain halfway
    sender_idle_pct = 14;
    receiver_stall_pct = 14;
    set_pool(100);
    random_cmds(60, 1'b1);
    wait_drained();
    random_cmds(60, 1'b1);

    // sender mostly idle again
    sender_idle_pct = 81;
    receiver_stall_pct = 0;
    set_pool(13);
    random_cmds(80, 1'b1);

    // empty pool
    sender_idle_pct = 0;
    receiver_stall_pct = 81;
    set_pool(0);
    random_cmds(20, 1'b1);

    // long receiver hold-off while commands keep coming
    receiver_stall_pct = 0;
    set_pool(777);
    holdoff_request = 400;
    random_cmds(120, 1'b1);

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d commands and %0d results over pool sizes 0 to 8191,",
             cmds_sent, results_seen);
    $display("with idle, stalling, hold-off and drain phases on both channels");
    if (error_count == 0 && pending_count == 0) begin
      $display("buddy_page_allocator_top test passed");
    end else begin
      $display("buddy_page_allocator_top test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("timeout waiting for the allocator");
    $display("buddy_page_allocator_top test failed");
    $finish;
  end

endmodule
